### rtl/core/slid_pkg.sv
package slid_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned ActionW = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  typedef enum logic [ActionW-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [StatusW-1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic              ins_en;
    logic              del_en;
    logic [ValueW-1:0] value;
  } slid_cmd_t;

endpackage

### rtl/core/slid_cell.sv
module slid_cell
  import slid_pkg::*;
#(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CW    = 5
) (
  input  logic              clk,
  input  slid_cmd_t         cmd,
  input  logic [CW-1:0]     count,
  input  logic [ValueW-1:0] prev_entry,
  input  logic              prev_gt,
  input  logic [ValueW-1:0] next_entry,
  output logic [ValueW-1:0] entry,
  output logic              gt,
  output logic              eq
);

  logic [ValueW-1:0] entry_r;
  logic [ValueW-1:0] entry_nxt;
  logic              occ;
  logic              at_tail;
  logic              ge;

  assign occ     = count > CW'(INDEX);
  assign at_tail = count == CW'(INDEX);
  assign gt      = occ && ($signed(entry_r) > $signed(cmd.value));
  assign ge      = occ && ($signed(entry_r) >= $signed(cmd.value));
  assign eq      = occ && (entry_r == cmd.value);
  assign entry   = entry_r;

  // sorted row: gt and ge are monotone across occupied cells, so the
  // neighbor's flag marks the insert point and the shift region
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins_en) begin
      if (prev_gt) begin
        entry_nxt = prev_entry;
      end else if (gt || at_tail) begin
        entry_nxt = cmd.value;
      end
    end else if (cmd.del_en && ge) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

### rtl/core/sorted_list_insert_delete.sv
// Sorted list held in a row of compare-and-shift cells, one entry per cell.
// Result registered in the cycle after the input transfer. Throughput: one item per
// cycle unless the output stalls; every cell compares and shifts in the same cycle,
// so the row's compare plus the found OR over DEPTH cells sets the clock path.
// Reset (rst_n, synchronous, active low) empties the list; entry data is not cleared.
module sorted_list_insert_delete
  import slid_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic signed [31:0]  in_tdata,   // [31:0] value
  input  logic [1:0]          in_tuser,   // [1:0] action
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata   // [1:0] status, [6:2] count, [7] is_empty,
                                          // [8] is_full, [15:9] zero
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [8:0]        out_data_r;
  logic [8:0]        out_data_nxt;
  logic              in_xfer;
  logic              found;
  logic              is_full;
  logic              is_empty;
  status_t           status;
  action_t           action;
  slid_cmd_t         cmd;
  logic [CW+4:0]     cnt_ext;

  logic [ValueW-1:0] entry_w [DEPTH];
  logic [DEPTH-1:0]  gt_w;
  logic [DEPTH-1:0]  eq_w;

  assign action    = action_t'(in_tuser);
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign is_full   = count_r == CW'(DEPTH);
  assign is_empty  = count_r == '0;
  assign found     = |eq_w;

  always_comb begin
    status        = ST_DONE;
    count_nxt     = count_r;
    cmd.ins_en    = 1'b0;
    cmd.del_en    = 1'b0;
    cmd.value     = in_tdata;
    case (action)
      ACT_INSERT: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          cmd.ins_en = in_xfer;
          count_nxt  = count_r + 1'b1;
        end
      end
      ACT_DELETE: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else if (!found) begin
          status = ST_ABSENT;
        end else begin
          cmd.del_en = in_xfer;
          count_nxt  = count_r - 1'b1;
        end
      end
      ACT_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  assign cnt_ext = {5'd0, count_nxt};

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_tvalid && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {count_nxt == CW'(DEPTH), count_nxt == '0, cnt_ext[4:0], status};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        count_r <= count_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ValueW-1:0] prev_entry;
    logic              prev_gt;
    logic [ValueW-1:0] next_entry;
    if (i == 0) begin : g_head
      assign prev_entry = '0;
      assign prev_gt    = 1'b0;
    end else begin : g_body
      assign prev_entry = entry_w[i-1];
      assign prev_gt    = gt_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_entry = entry_w[i];
    end else begin : g_mid
      assign next_entry = entry_w[i+1];
    end
    slid_cell #(
      .INDEX(i),
      .CW   (CW)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count_r),
      .prev_entry(prev_entry),
      .prev_gt   (prev_gt),
      .next_entry(next_entry),
      .entry     (entry_w[i]),
      .gt        (gt_w[i]),
      .eq        (eq_w[i])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count above depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (action == ACT_CLEAR) |=> count_r == '0)
    else $error("clear did not empty the list");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_en |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the list");

  a_flags_track: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[7] == is_empty) && (out_data_r[8] == is_full))
    else $error("result flags disagree with held count");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.ins_en && cmd.del_en))
    else $error("insert and delete in the same cycle");

endmodule
